@@ rtl/gbfp_pkg.sv @@
// Shared types, constants and the message lookup for the binary frame parser.
package gbfp_pkg;

    localparam logic [7:0] SYNC_CHAR_1 = 8'hB5;
    localparam logic [7:0] SYNC_CHAR_2 = 8'h62;

    localparam logic [7:0] CLASS_NAV = 8'h01;
    localparam logic [7:0] CLASS_RXM = 8'h02;

    localparam logic [7:0] ID_NAV_POSLLH  = 8'h02;
    localparam logic [7:0] ID_NAV_SOL     = 8'h06;
    localparam logic [7:0] ID_NAV_TIMEUTC = 8'h21;
    localparam logic [7:0] ID_NAV_DOP     = 8'h04;
    localparam logic [7:0] ID_NAV_SVINFO  = 8'h30;
    localparam logic [7:0] ID_NAV_VELNED  = 8'h12;
    localparam logic [7:0] ID_RXM_SVSI    = 8'h20;

    localparam logic [15:0] MAX_LEN_RESET = 16'd998;

    typedef enum logic [2:0] {
        MSG_POSLLH  = 3'd0,
        MSG_SOL     = 3'd1,
        MSG_TIMEUTC = 3'd2,
        MSG_DOP     = 3'd3,
        MSG_SVINFO  = 3'd4,
        MSG_VELNED  = 3'd5,
        MSG_SVSI    = 3'd6
    } t_msg;

    typedef enum logic [1:0] {
        EV_PAYLOAD  = 2'd0,
        EV_GOOD     = 2'd1,
        EV_BAD      = 2'd2,
        EV_OVERSIZE = 2'd3
    } t_event;

    typedef struct packed {
        logic        valid;
        t_event      kind;
        logic [7:0]  data;
        logic [2:0]  code;
        logic [15:0] index;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } t_lookup;

    function automatic t_lookup msg_lookup(input logic rxm_class, input logic [7:0] id);
        t_lookup res;
        res.hit  = 1'b1;
        res.code = MSG_POSLLH;
        if (rxm_class) begin
            res.hit  = (id == ID_RXM_SVSI);
            res.code = MSG_SVSI;
        end else begin
            case (id)
                ID_NAV_POSLLH:  res.code = MSG_POSLLH;
                ID_NAV_SOL:     res.code = MSG_SOL;
                ID_NAV_TIMEUTC: res.code = MSG_TIMEUTC;
                ID_NAV_DOP:     res.code = MSG_DOP;
                ID_NAV_SVINFO:  res.code = MSG_SVINFO;
                ID_NAV_VELNED:  res.code = MSG_VELNED;
                default:        res.hit  = 1'b0;
            endcase
        end
        return res;
    endfunction

endpackage

@@ rtl/gbfp_parser.sv @@
// Frame state machine, checksum sums and result generation for one byte per step.
module gbfp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic [15:0]       i_max_len,
    output gbfp_pkg::t_result o_res
);
    import gbfp_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_SYNC1  = 3'd1,
        PH_CLASS  = 3'd2,
        PH_ID     = 3'd3,
        PH_LEN_LO = 3'd4,
        PH_LEN_HI = 3'd5,
        PH_BODY   = 3'd6,
        PH_CK_B   = 3'd7
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [7:0]  r_sum_a,     n_sum_a;
    logic [7:0]  r_sum_b,     n_sum_b;
    logic [15:0] r_frame_len, n_frame_len;
    logic [15:0] r_seen,      n_seen;
    logic [2:0]  r_msg,       n_msg;
    logic        r_rxm_class, n_rxm_class;
    logic [7:0]  r_ck_a,      n_ck_a;

    t_result     res;
    t_lookup     lk;
    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [15:0] len_full;

    always_comb begin
        lk        = msg_lookup(r_rxm_class, i_byte);
        sum_a_add = r_sum_a + i_byte;
        sum_b_add = r_sum_b + sum_a_add;
        len_full  = {i_byte, r_frame_len[7:0]};

        n_phase     = r_phase;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_frame_len = r_frame_len;
        n_seen      = r_seen;
        n_msg       = r_msg;
        n_rxm_class = r_rxm_class;
        n_ck_a      = r_ck_a;

        res.valid = 1'b0;
        res.kind  = EV_PAYLOAD;
        res.data  = 8'd0;
        res.code  = r_msg;
        res.index = r_frame_len;

        case (r_phase)
            PH_HUNT: begin
                if (i_byte == SYNC_CHAR_1) begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_SYNC1: begin
                n_phase = (i_byte == SYNC_CHAR_2) ? PH_CLASS : PH_HUNT;
            end
            PH_CLASS: begin
                if (i_byte == CLASS_NAV || i_byte == CLASS_RXM) begin
                    n_sum_a     = sum_a_add;
                    n_sum_b     = sum_b_add;
                    n_rxm_class = (i_byte == CLASS_RXM);
                    n_phase     = PH_ID;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_ID: begin
                if (lk.hit) begin
                    n_sum_a = sum_a_add;
                    n_sum_b = sum_b_add;
                    n_msg   = lk.code;
                    n_phase = PH_LEN_LO;
                end else begin
                    n_phase = PH_HUNT;
                end
            end
            PH_LEN_LO: begin
                n_sum_a     = sum_a_add;
                n_sum_b     = sum_b_add;
                n_frame_len = {8'd0, i_byte};
                n_phase     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_sum_a     = sum_a_add;
                n_sum_b     = sum_b_add;
                n_frame_len = len_full;
                n_seen      = 16'd0;
                if (len_full > i_max_len) begin
                    res.valid = 1'b1;
                    res.kind  = EV_OVERSIZE;
                    res.index = len_full;
                    n_phase   = PH_HUNT;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_seen < r_frame_len) begin
                    n_sum_a   = sum_a_add;
                    n_sum_b   = sum_b_add;
                    n_seen    = r_seen + 16'd1;
                    res.valid = 1'b1;
                    res.kind  = EV_PAYLOAD;
                    res.data  = i_byte;
                    res.index = r_seen;
                end else begin
                    n_ck_a  = i_byte;
                    n_phase = PH_CK_B;
                end
            end
            PH_CK_B: begin
                res.valid = 1'b1;
                res.kind  = (r_ck_a == r_sum_a && i_byte == r_sum_b) ? EV_GOOD : EV_BAD;
                n_phase   = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase

        // Every return to hunting restores the reset values of the frame state.
        if (n_phase == PH_HUNT) begin
            n_sum_a     = 8'd0;
            n_sum_b     = 8'd0;
            n_frame_len = 16'd0;
            n_seen      = 16'd0;
            n_msg       = 3'd0;
            n_rxm_class = 1'b0;
            n_ck_a      = 8'd0;
        end

        o_res       = res;
        o_res.valid = res.valid & i_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_sum_a     <= 8'd0;
            r_sum_b     <= 8'd0;
            r_frame_len <= 16'd0;
            r_seen      <= 16'd0;
            r_msg       <= 3'd0;
            r_rxm_class <= 1'b0;
            r_ck_a      <= 8'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_sum_a     <= n_sum_a;
            r_sum_b     <= n_sum_b;
            r_frame_len <= n_frame_len;
            r_seen      <= n_seen;
            r_msg       <= n_msg;
            r_rxm_class <= n_rxm_class;
            r_ck_a      <= n_ck_a;
        end
    end

    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_seen <= r_frame_len))
        else $error("payload count passed the frame length");

    a_hunt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HUNT) |-> (r_sum_a == 8'd0 && r_sum_b == 8'd0 && r_frame_len == 16'd0))
        else $error("frame state not cleared while hunting");

    a_end_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kind != EV_PAYLOAD) |=> (r_phase == PH_HUNT))
        else $error("parser did not return to hunting after a frame end");

    a_step_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> i_step)
        else $error("result raised without a step");

endmodule

@@ rtl/gnss_binary_frame_parser_top.sv @@
// Top level of the binary frame parser: input register, parser and result register.
//
//  Channel     Direction  Request when          Contents
//  s_axis      in         tvalid & tready       tdata[7:0] rx_byte
//  m_axis      out        tvalid & tready       tuser kind, tdata byte/code/index
//  cfg         in         valid & ready         data[15:0] max_payload_length
//
// One byte is taken per cycle while the result register is not stalled; a result is registered in the result register.
// The parser state advances in one step per byte from the input register to the result register.
// Reset is synchronous and active low; it returns the parser to hunting and the limit to 998.
// When the result register is full and not taken, a byte in the input register holds and tready drops.
// Configuration writes are always ready.
module gnss_binary_frame_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] payload_byte, [10:8] message_code,
                                          // [26:11] byte_index, [31:27] zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] event_kind
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data        // [15:0] max_payload_length
);
    import gbfp_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [15:0] r_max_len;
    logic        r_out_valid;
    t_result     r_out;
    t_result     res;
    logic        step;

    assign step            = r_in_valid & (~r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~r_in_valid | step;
    assign o_cfg_ready     = 1'b1;

    gbfp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_in_byte),
        .i_max_len (r_max_len),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_len   <= MAX_LEN_RESET;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (step) begin
                r_out_valid <= res.valid;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_max_len <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
        end
        if (step && res.valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tdata  = {5'd0, r_out.index, r_out.code, r_out.data};

endmodule
